FILE: hw/rtl/pending_ack_timeout_table_macros.svh
`ifndef PENDING_ACK_TIMEOUT_TABLE_MACROS_SVH
`define PENDING_ACK_TIMEOUT_TABLE_MACROS_SVH

// Property check, clocked on clk_i, off during reset.
`define PAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen.
`define PAT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/pat_pkg.sv
package pat_pkg;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MAX_REPORTS = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_REPORTS + 1);

  localparam int unsigned OP_W    = 2;
  localparam int unsigned UID_W   = 16;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned KEY_W   = UID_W + CMD_W;
  localparam int unsigned STAMP_W = 32;

  localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 32'd3000;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_ACK    = 2'd1,
    OP_CHECK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

endpackage

FILE: hw/rtl/pat_if.sv
interface pat_req_if;
  import pat_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [UID_W-1:0]   partner_uid;
  logic [CMD_W-1:0]   cmd_code;
  logic [STAMP_W-1:0] now;

  modport source (output valid, op, partner_uid, cmd_code, now, input ready);
  modport sink   (input valid, op, partner_uid, cmd_code, now, output ready);
endinterface

interface pat_rsp_if;
  import pat_pkg::*;

  logic             valid;
  logic             ready;
  logic [UID_W-1:0] expired_uid;
  logic [CMD_W-1:0] expired_command;
  logic             last;

  modport source (output valid, expired_uid, expired_command, last, input ready);
  modport sink   (input valid, expired_uid, expired_command, last, output ready);
endinterface

FILE: hw/rtl/pat_ram.sv
module pat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pending_ack_timeout_table.sv
// Table of commands that wait for an acknowledgement. A record transfer puts
// its key and time stamp in the lowest free slot (dropped when full), an
// acknowledge transfer frees the lowest valid slot with that key, and a check
// transfer reports, in slot order, every valid slot older than timeout_q,
// at most MAX_REPORTS, with last set on the final report. The input is taken
// only while the sequencer is idle. Each slot is visited in ST_READ (RAM
// read) and then ST_EVAL (subtract and compare); a check stalls in ST_EVAL
// on a further expired slot while the result side holds an unaccepted
// report, and hands over the final report from ST_FLUSH. Slot key and stamp
// live in a single-port-read RAM; the valid bits are flip-flops cleared by
// reset.
`include "pending_ack_timeout_table_macros.svh"

module pending_ack_timeout_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pat_req_if.sink                     req_i,
  pat_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [pat_pkg::STAMP_W-1:0] cfg_wdata_i
);
  import pat_pkg::*;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [STAMP_W-1:0] now_q, now_d;
  logic [STAMP_W-1:0] timeout_q;
  logic [SLOTS-1:0]   slot_valid_q, slot_valid_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               held_valid_q, held_valid_d;
  logic [KEY_W-1:0]   held_key_q, held_key_d;

  logic               out_valid_q, out_valid_d;
  logic [UID_W-1:0]   out_uid_q, out_uid_d;
  logic [CMD_W-1:0]   out_cmd_q, out_cmd_d;
  logic               out_last_q, out_last_d;

  logic               ram_we;
  slot_t              ram_wdata;
  slot_t              ram_rdata;

  logic               out_free;
  logic               cur_valid;
  logic [STAMP_W-1:0] age;
  logic               expired;
  logic               stall;
  logic               stop;
  logic               last_idx;
  logic               scan_start;
  logic               cnt_ok;

  pat_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata.key   = key_q;
  assign ram_wdata.stamp = now_q;

  assign req_i.ready           = (state_q == ST_IDLE);
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.expired_uid     = out_uid_q;
  assign rsp_o.expired_command = out_cmd_q;
  assign rsp_o.last            = out_last_q;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign cur_valid = slot_valid_q[idx_q];
  assign age       = now_q - ram_rdata.stamp;
  assign expired   = cur_valid && (age > timeout_q);
  assign last_idx  = (idx_q == IDX_W'(SLOTS - 1));

  assign scan_start = req_i.valid && req_i.ready &&
                      (req_i.op inside {OP_RECORD, OP_ACK, OP_CHECK});
  assign cnt_ok     = (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_REPORTS));

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    op_d         = op_q;
    key_d        = key_q;
    now_d        = now_q;
    slot_valid_d = slot_valid_q;
    cnt_d        = cnt_q;
    held_valid_d = held_valid_q;
    held_key_d   = held_key_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_uid_d    = out_uid_q;
    out_cmd_d    = out_cmd_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    stall        = 1'b0;
    stop         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d         = req_i.op;
          key_d        = {req_i.partner_uid, req_i.cmd_code};
          now_d        = req_i.now;
          idx_d        = '0;
          cnt_d        = '0;
          held_valid_d = 1'b0;
          if (req_i.op inside {OP_RECORD, OP_ACK, OP_CHECK}) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        case (op_q)
          OP_RECORD: begin
            if (!cur_valid) begin
              ram_we              = 1'b1;
              slot_valid_d[idx_q] = 1'b1;
              stop                = 1'b1;
            end
          end
          OP_ACK: begin
            if (cur_valid && (ram_rdata.key == key_q)) begin
              slot_valid_d[idx_q] = 1'b0;
              stop                = 1'b1;
            end
          end
          OP_CHECK: begin
            if (expired) begin
              if (held_valid_q && !out_free) begin
                stall = 1'b1;
              end else begin
                if (held_valid_q) begin
                  out_valid_d = 1'b1;
                  out_uid_d   = held_key_q[KEY_W-1:CMD_W];
                  out_cmd_d   = held_key_q[CMD_W-1:0];
                  out_last_d  = 1'b0;
                end
                held_valid_d = 1'b1;
                held_key_d   = ram_rdata.key;
                cnt_d        = cnt_q + 1'b1;
                if (cnt_q == CNT_W'(MAX_REPORTS - 1)) begin
                  stop = 1'b1;
                end
              end
            end
          end
          default: begin
            stop = 1'b1;
          end
        endcase

        if (!stall) begin
          if (stop) begin
            state_d = (op_q == OP_CHECK) ? ST_FLUSH : ST_IDLE;
          end else if (last_idx) begin
            state_d = held_valid_d ? ST_FLUSH : ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_uid_d    = held_key_q[KEY_W-1:CMD_W];
          out_cmd_d    = held_key_q[CMD_W-1:0];
          out_last_d   = 1'b1;
          held_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      slot_valid_q <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      timeout_q    <= TIMEOUT_RESET;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      slot_valid_q <= slot_valid_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    now_q      <= now_d;
    held_key_q <= held_key_d;
    out_uid_q  <= out_uid_d;
    out_cmd_q  <= out_cmd_d;
    out_last_q <= out_last_d;
  end

  `PAT_ASSERT(a_one_slot, $countones(slot_valid_q ^ $past(slot_valid_q)) <= 1, "two slots changed")
  `PAT_ASSERT(a_flush_has_report, state_q == ST_FLUSH |-> held_valid_q, "flush without a held report")
  `PAT_ASSERT(a_report_bound, held_valid_q |-> cnt_ok, "held report count out of range")
  `PAT_ASSERT(a_op_starts_scan, scan_start |=> state_q == ST_READ && idx_q == '0, "no scan")

endmodule
